[sv/pts_pkg.sv]
// ----------------------------------------------------------------------------
// pts_pkg - shared types and constants for the priority task scheduler
// Sizes of the ready queues and sleep list, command and status codes, and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pts_pkg;

   localparam int PRIORITY_LEVELS = 3;
   localparam int MAX_TASKS       = 16;

   localparam int TASK_W  = 4;
   localparam int CMD_W   = 2;
   localparam int TIME_W  = 64;
   localparam int WOKEN_W = 5;
   localparam int STAT_W  = 2;

   localparam int IDX_W   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_W   = $clog2(MAX_TASKS + 1);
   localparam int SUM_W   = CNT_W + 1;
   localparam int Q_W     = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
   localparam int ADDR_W  = $clog2(PRIORITY_LEVELS * MAX_TASKS);
   localparam int WSAT_W  = (CNT_W > WOKEN_W) ? CNT_W : WOKEN_W;
   localparam int WOKEN_MAX = (1 << WOKEN_W) - 1;

   typedef enum logic [CMD_W-1:0] {
      CMD_RESUME = 2'd0,
      CMD_SLEEP  = 2'd1,
      CMD_YIELD  = 2'd2,
      CMD_BLOCK  = 2'd3
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_NONE = 2'd2
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;     // input word taken this cycle
      logic scan_step;  // sleep list sweep active
      logic pick;       // dequeue from highest non-empty queue
      logic load;       // load result register
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_done;
   } dp_stat_type;

endpackage

[sv/pts_ifs.sv]
// ----------------------------------------------------------------------------
// pts_ifs - request and response channels of the task scheduler
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface pts_req_if;
   logic                         valid;
   logic                         ready;
   logic [pts_pkg::CMD_W-1:0]    cmd;
   logic [pts_pkg::TASK_W-1:0]   task_id;
   logic [pts_pkg::TIME_W-1:0]   wake_time;
   logic [pts_pkg::TIME_W-1:0]   now_time;
   logic                         idle_task;

   modport source (output valid, cmd, task_id, wake_time, now_time, idle_task,
                   input ready);
   modport sink   (input valid, cmd, task_id, wake_time, now_time, idle_task,
                   output ready);
endinterface

interface pts_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [pts_pkg::TASK_W-1:0]   next_task;
   logic                         switch_needed;
   logic [pts_pkg::WOKEN_W-1:0]  woken_count;
   logic [pts_pkg::STAT_W-1:0]   status;

   modport source (output valid, next_task, switch_needed, woken_count, status,
                   input ready);
   modport sink   (input valid, next_task, switch_needed, woken_count, status,
                   output ready);
endinterface

[sv/pts_ctrl.sv]
// ----------------------------------------------------------------------------
// pts_ctrl - scheduler sequencer
// Steps each command through accept, sleep list sweep, dequeue and result;
// resume, sleep and idle yield go straight from accept to result.
module pts_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [pts_pkg::CMD_W-1:0] req_cmd,
   input  logic                     req_idle_task,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output pts_pkg::dp_cmd_type      dp_cmd,
   input  pts_pkg::dp_stat_type     dp_stat
);
   import pts_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_PICK,
      S_FINISH
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      accept;
   cmd_type   cmd;

   assign cmd       = cmd_type'(req_cmd);
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      dp_cmd.accept    = accept;
      dp_cmd.scan_step = (state_ff == S_SCAN);
      dp_cmd.pick      = (state_ff == S_PICK);
      dp_cmd.load      = (state_ff == S_FINISH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if ((cmd == CMD_BLOCK) || ((cmd == CMD_YIELD) && !req_idle_task)) begin
                     state_ff <= S_SCAN;
                  end else begin
                     state_ff <= S_FINISH;
                  end
               end
            end
            S_SCAN: begin
               if (dp_stat.scan_done) begin
                  state_ff <= S_PICK;
               end
            end
            S_PICK: begin
               state_ff <= S_FINISH;
            end
            S_FINISH: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

[sv/pts_dp.sv]
// ----------------------------------------------------------------------------
// pts_dp - scheduler datapath
// Ready queue memory with per-queue head/count, sleep list memory with a
// compacting sweep, deadline compare and the result register.
// ----------------------------------------------------------------------------
module pts_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  pts_pkg::dp_cmd_type         dp_cmd,
   output pts_pkg::dp_stat_type        dp_stat,
   input  logic [pts_pkg::CMD_W-1:0]   req_cmd,
   input  logic [pts_pkg::TASK_W-1:0]  req_task_id,
   input  logic [pts_pkg::TIME_W-1:0]  req_wake_time,
   input  logic [pts_pkg::TIME_W-1:0]  req_now_time,
   input  logic                        req_idle_task,
   output logic [pts_pkg::TASK_W-1:0]  rsp_next_task,
   output logic                        rsp_switch_needed,
   output logic [pts_pkg::WOKEN_W-1:0] rsp_woken_count,
   output logic [pts_pkg::STAT_W-1:0]  rsp_status
);
   import pts_pkg::*;

   // memories
   logic [TASK_W-1:0] ready_mem [PRIORITY_LEVELS*MAX_TASKS];
   logic [TASK_W-1:0] sl_id_mem [MAX_TASKS];
   logic [TIME_W-1:0] sl_dl_mem [MAX_TASKS];

   // queue control
   logic [IDX_W-1:0] head_ff [PRIORITY_LEVELS];
   logic [IDX_W-1:0] head_in [PRIORITY_LEVELS];
   logic [CNT_W-1:0] cnt_ff  [PRIORITY_LEVELS];
   logic [CNT_W-1:0] cnt_in  [PRIORITY_LEVELS];
   logic [CNT_W-1:0] sl_count_ff, sl_count_in;

   // per-item state
   logic [TASK_W-1:0] id_ff;
   logic [TIME_W-1:0] now_ff;
   logic              dropped_ff, dropped_in;
   logic [CNT_W-1:0]  woken_ff, woken_in;
   logic [CNT_W-1:0]  kept_ff, kept_in;
   logic [CNT_W-1:0]  scan_idx_ff, scan_idx_in;
   logic              ev_vld_ff, ev_vld_in;
   logic              picked_ff, picked_in;
   logic              empty_ff, empty_in;

   // registered read data
   logic [TASK_W-1:0] sl_id_rd_ff;
   logic [TIME_W-1:0] sl_dl_rd_ff;
   logic [TASK_W-1:0] rd_task_ff;

   cmd_type           cmd;
   logic              push_q1, push_req, push_full, push_en;
   logic [TASK_W-1:0] push_id;
   logic [IDX_W-1:0]  push_head;
   logic [CNT_W-1:0]  push_cnt;
   logic [SUM_W-1:0]  tail_sum;
   logic [IDX_W-1:0]  tail_pos;
   logic [ADDR_W-1:0] push_addr;
   logic              eval, expired, scan_issue, scan_done;
   logic              pick_any;
   logic [Q_W-1:0]    pick_q;
   logic [IDX_W-1:0]  pick_head;
   logic [ADDR_W-1:0] pick_addr;
   logic              pick_rd;
   logic              sl_wr_en;
   logic [IDX_W-1:0]  sl_wr_addr;
   logic [TASK_W-1:0] sl_wr_id;
   logic [TIME_W-1:0] sl_wr_dl;
   logic              sleep_ok;
   logic [WSAT_W-1:0] woken_ext;
   logic [WOKEN_W-1:0] woken_sat;

   assign cmd = cmd_type'(req_cmd);

   // sweep: issue a read per cycle, evaluate it the next cycle
   assign eval       = dp_cmd.scan_step && ev_vld_ff;
   assign expired    = (sl_dl_rd_ff <= now_ff);
   assign scan_issue = dp_cmd.scan_step && (scan_idx_ff != sl_count_ff);
   assign scan_done  = dp_cmd.scan_step && (scan_idx_ff == sl_count_ff) && !ev_vld_ff;
   assign dp_stat.scan_done = scan_done;

   // ready queue append: resume (q0), non-idle yield (q1) or woken sleeper (q0)
   always_comb begin
      push_q1   = dp_cmd.accept && (cmd == CMD_YIELD) && !req_idle_task;
      push_req  = (dp_cmd.accept && (cmd == CMD_RESUME)) || push_q1 || (eval && expired);
      push_id   = eval ? sl_id_rd_ff : req_task_id;
      push_head = push_q1 ? head_ff[1] : head_ff[0];
      push_cnt  = push_q1 ? cnt_ff[1]  : cnt_ff[0];
      push_full = (push_cnt == CNT_W'(MAX_TASKS));
      push_en   = push_req && !push_full;
      tail_sum  = SUM_W'(push_head) + SUM_W'(push_cnt);
      if (tail_sum >= SUM_W'(MAX_TASKS)) begin
         tail_sum = tail_sum - SUM_W'(MAX_TASKS);
      end
      tail_pos  = tail_sum[IDX_W-1:0];
      push_addr = (push_q1 ? ADDR_W'(MAX_TASKS) : ADDR_W'(0)) + ADDR_W'(tail_pos);
   end

   // highest priority non-empty queue
   always_comb begin
      pick_any  = 1'b0;
      pick_q    = '0;
      pick_head = '0;
      for (int q = PRIORITY_LEVELS - 1; q >= 0; q--) begin
         if (cnt_ff[q] != '0) begin
            pick_any  = 1'b1;
            pick_q    = Q_W'(q);
            pick_head = head_ff[q];
         end
      end
      pick_addr = ADDR_W'(pick_q) * ADDR_W'(MAX_TASKS) + ADDR_W'(pick_head);
      pick_rd   = dp_cmd.pick && pick_any;
   end

   always_comb begin
      for (int q = 0; q < PRIORITY_LEVELS; q++) begin
         head_in[q] = head_ff[q];
         cnt_in[q]  = cnt_ff[q];
         if (push_en && ((q == 1) == push_q1) && (q < 2)) begin
            cnt_in[q] = cnt_ff[q] + CNT_W'(1);
         end
         if (pick_rd && (pick_q == Q_W'(q))) begin
            cnt_in[q]  = cnt_ff[q] - CNT_W'(1);
            head_in[q] = (head_ff[q] == IDX_W'(MAX_TASKS - 1)) ? '0
                                                             : head_ff[q] + IDX_W'(1);
         end
      end
   end

   // sleep list writes: append on sleep, compact during the sweep
   always_comb begin
      sleep_ok   = dp_cmd.accept && (cmd == CMD_SLEEP) && (sl_count_ff != CNT_W'(MAX_TASKS));
      sl_wr_en   = sleep_ok || (eval && !expired);
      sl_wr_addr = eval ? kept_ff[IDX_W-1:0] : sl_count_ff[IDX_W-1:0];
      sl_wr_id   = eval ? sl_id_rd_ff : req_task_id;
      sl_wr_dl   = eval ? sl_dl_rd_ff : req_wake_time;
   end

   always_comb begin
      sl_count_in = sl_count_ff;
      dropped_in  = dropped_ff;
      woken_in    = woken_ff;
      kept_in     = kept_ff;
      scan_idx_in = scan_idx_ff;
      ev_vld_in   = scan_issue;
      picked_in   = picked_ff;
      empty_in    = empty_ff;
      if (dp_cmd.accept) begin
         woken_in    = '0;
         kept_in     = '0;
         scan_idx_in = '0;
         picked_in   = 1'b0;
         empty_in    = 1'b0;
         unique case (cmd)
            CMD_RESUME: dropped_in = push_full;
            CMD_SLEEP:  dropped_in = (sl_count_ff == CNT_W'(MAX_TASKS));
            CMD_YIELD:  dropped_in = !req_idle_task && push_full;
            CMD_BLOCK:  dropped_in = 1'b0;
            default:    dropped_in = 1'b0;
         endcase
         if (sleep_ok) begin
            sl_count_in = sl_count_ff + CNT_W'(1);
         end
      end
      if (scan_issue) begin
         scan_idx_in = scan_idx_ff + CNT_W'(1);
      end
      if (eval) begin
         if (!expired) begin
            kept_in = kept_ff + CNT_W'(1);
         end else if (push_full) begin
            dropped_in = 1'b1;
         end else begin
            woken_in = woken_ff + CNT_W'(1);
         end
      end
      if (scan_done) begin
         sl_count_in = kept_ff;
      end
      if (dp_cmd.pick) begin
         picked_in = 1'b1;
         empty_in  = !pick_any;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int q = 0; q < PRIORITY_LEVELS; q++) begin
            head_ff[q] <= '0;
            cnt_ff[q]  <= '0;
         end
         sl_count_ff <= '0;
         dropped_ff  <= 1'b0;
         woken_ff    <= '0;
         kept_ff     <= '0;
         scan_idx_ff <= '0;
         ev_vld_ff   <= 1'b0;
         picked_ff   <= 1'b0;
         empty_ff    <= 1'b0;
      end else begin
         for (int q = 0; q < PRIORITY_LEVELS; q++) begin
            head_ff[q] <= head_in[q];
            cnt_ff[q]  <= cnt_in[q];
         end
         sl_count_ff <= sl_count_in;
         dropped_ff  <= dropped_in;
         woken_ff    <= woken_in;
         kept_ff     <= kept_in;
         scan_idx_ff <= scan_idx_in;
         ev_vld_ff   <= ev_vld_in;
         picked_ff   <= picked_in;
         empty_ff    <= empty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.accept) begin
         id_ff  <= req_task_id;
         now_ff <= req_now_time;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         ready_mem[push_addr] <= push_id;
      end
      if (pick_rd) begin
         rd_task_ff <= ready_mem[pick_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (sl_wr_en) begin
         sl_id_mem[sl_wr_addr] <= sl_wr_id;
         sl_dl_mem[sl_wr_addr] <= sl_wr_dl;
      end
      if (scan_issue) begin
         sl_id_rd_ff <= sl_id_mem[scan_idx_ff[IDX_W-1:0]];
         sl_dl_rd_ff <= sl_dl_mem[scan_idx_ff[IDX_W-1:0]];
      end
   end

   // result register
   assign woken_ext = WSAT_W'(woken_ff);
   assign woken_sat = (woken_ext > WSAT_W'(WOKEN_MAX)) ? WOKEN_W'(WOKEN_MAX)
                                                     : woken_ext[WOKEN_W-1:0];

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         rsp_woken_count <= woken_sat;
         if (picked_ff && !empty_ff) begin
            rsp_next_task     <= rd_task_ff;
            rsp_switch_needed <= (rd_task_ff != id_ff);
            rsp_status        <= dropped_ff ? ST_FULL : ST_OK;
         end else begin
            rsp_next_task     <= id_ff;
            rsp_switch_needed <= 1'b0;
            if (picked_ff) begin
               rsp_status <= ST_NONE;
            end else begin
               rsp_status <= dropped_ff ? ST_FULL : ST_OK;
            end
         end
      end
   end

endmodule

[sv/priority_task_scheduler_with_sleep.sv]
// ----------------------------------------------------------------------------
// priority_task_scheduler_with_sleep - multilevel ready queues plus sleep list
// Resume/sleep/yield/block commands in, one scheduling result word out.
// ----------------------------------------------------------------------------
//  channel | dir | fields                                             | role
//  req_ch  | in  | cmd, task_id, wake_time, now_time, idle_task       | command word
//  rsp_ch  | out | next_task, switch_needed, woken_count, status      | result word
//
//  Resume, sleep and idle yield go from accept straight to S_FINISH, then result valid.
//  Block and non-idle yield pass through S_SCAN, S_PICK and S_FINISH; the sweep
//  reads one entry per cycle through its single read port.
//  One word in flight; a new word is taken in the cycle the result is taken.
//  Synchronous active-high reset empties all queues and the sleep list.
//  Result holds steady while rsp_ch.ready is low.
// ----------------------------------------------------------------------------
module priority_task_scheduler_with_sleep (
   input logic       clock,
   input logic       reset,
   pts_req_if.sink   req_ch,
   pts_rsp_if.source rsp_ch
);
   import pts_pkg::*;

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   // sequencer: owns handshake and result valid
   pts_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_cmd       (req_ch.cmd),
      .req_idle_task (req_ch.idle_task),
      .req_ready     (req_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .dp_cmd        (dp_cmd),
      .dp_stat       (dp_stat)
   );

   // queues, sleep list and result register
   pts_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .dp_cmd            (dp_cmd),
      .dp_stat           (dp_stat),
      .req_cmd           (req_ch.cmd),
      .req_task_id       (req_ch.task_id),
      .req_wake_time     (req_ch.wake_time),
      .req_now_time      (req_ch.now_time),
      .req_idle_task     (req_ch.idle_task),
      .rsp_next_task     (rsp_ch.next_task),
      .rsp_switch_needed (rsp_ch.switch_needed),
      .rsp_woken_count   (rsp_ch.woken_count),
      .rsp_status        (rsp_ch.status)
   );

endmodule
